// ===== design/slcf_pkg.sv =====
// Shared constants and control types of the sync/length/checksum frame receiver.
package slcf_pkg;

  // Field widths of the byte channel and of the result channel.
  localparam int BYTE_W     = 8;
  localparam int POSITION_W = 4;
  localparam int LENGTH_W   = 5;

  // Sync byte value after reset.
  localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hAA;

  // Number of RAM banks: one fills while the other drains.
  localparam int BANKS = 2;

  // Notice from the back end that a payload bank has been fully drained.
  typedef struct packed {
    logic valid;
    logic bank;
  } slcf_release_t;

endpackage

// ===== design/slcf_rx_if.sv =====
// Received-byte channel: valid/ready handshake carrying one byte per item.
interface slcf_rx_if import slcf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== design/slcf_res_if.sv =====
// Result channel: one payload byte of a verified frame per item.
interface slcf_res_if import slcf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [BYTE_W-1:0]     payload_byte;
  logic [POSITION_W-1:0] payload_position;
  logic [LENGTH_W-1:0]   frame_length;
  logic                  last_of_frame;

  modport source (output valid, output payload_byte, output payload_position,
                  output frame_length, output last_of_frame, input ready);
  modport sink   (input valid, input payload_byte, input payload_position,
                  input frame_length, input last_of_frame, output ready);
endinterface

// ===== design/slcf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module slcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/slcf_queue.sv =====
// Two-entry frame descriptor queue between the front end and the back end.
module slcf_queue #(
  parameter int WIDTH = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data,
  input  logic             pop_ready
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Descriptor storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== design/slcf_front.sv =====
// Front end: parses sync, length, payload and checksum bytes and queues good frames.
module slcf_front import slcf_pkg::*; #(
  parameter int MAX_PAYLOAD = 16,
  localparam int LW = $clog2(MAX_PAYLOAD + 1),
  localparam int PW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
  localparam int CW = $clog2(MAX_PAYLOAD + 3),
  localparam int AW = $clog2(BANKS * MAX_PAYLOAD),
  localparam int DW = 1 + LW
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [BYTE_W-1:0] cfg_wdata,
  slcf_rx_if.sink           rx,
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output logic [BYTE_W-1:0] ram_wdata,
  output logic              push_valid,
  output logic [DW-1:0]     push_desc,
  input  logic              push_ready,
  input  slcf_release_t     rel
);

  // Byte count values: sync taken, then length taken.
  localparam logic [CW-1:0] COUNT_SYNC   = CW'(1);
  localparam logic [CW-1:0] COUNT_HEADER = CW'(2);

  logic [BYTE_W-1:0] sync_value;
  logic              receiving;
  logic              receiving_next;
  logic [CW-1:0]     byte_count;
  logic [CW-1:0]     byte_count_next;
  logic [LW-1:0]     announced_length;
  logic [LW-1:0]     announced_length_next;
  logic [BYTE_W-1:0] running_sum;
  logic [BYTE_W-1:0] running_sum_next;
  logic              wr_bank;
  logic [BANKS-1:0]  bank_busy;
  logic [BANKS-1:0]  bank_busy_next;
  logic              accept;
  logic [PW-1:0]     pos;
  logic [BYTE_W-1:0] b;

  // Take a byte only while the bank being filled is free and a good frame can be queued.
  assign rx.ready  = !bank_busy[wr_bank] && push_ready;
  assign accept    = rx.valid && rx.ready;
  assign b         = rx.rx_byte;
  assign pos       = PW'(byte_count - COUNT_HEADER);
  assign ram_wdata = b;
  assign ram_waddr = AW'(pos) + (wr_bank ? AW'(MAX_PAYLOAD) : {AW{1'b0}});
  assign push_desc = {wr_bank, announced_length};

  // Frame parser.
  always_comb begin
    receiving_next        = receiving;
    byte_count_next       = byte_count;
    announced_length_next = announced_length;
    running_sum_next      = running_sum;
    ram_we                = 1'b0;
    push_valid            = 1'b0;
    if (accept) begin
      priority if (!receiving) begin
        // Hunting for the sync byte.
        if (b == sync_value) begin
          receiving_next        = 1'b1;
          byte_count_next       = COUNT_SYNC;
          announced_length_next = '0;
          running_sum_next      = b;
        end
      end else if (byte_count == COUNT_SYNC) begin
        // Length byte: an empty or oversized frame is dropped.
        if (b == '0 || b > BYTE_W'(MAX_PAYLOAD)) begin
          receiving_next        = 1'b0;
          byte_count_next       = '0;
          announced_length_next = '0;
          running_sum_next      = '0;
        end else begin
          announced_length_next = LW'(b);
          running_sum_next      = running_sum + b;
          byte_count_next       = COUNT_HEADER;
        end
      end else if (byte_count < CW'(announced_length) + COUNT_HEADER) begin
        // Payload byte goes into the current bank.
        ram_we           = 1'b1;
        running_sum_next = running_sum + b;
        byte_count_next  = byte_count + CW'(1);
      end else begin
        // Checksum byte: a match hands the bank to the back end.
        push_valid            = (b == running_sum);
        receiving_next        = 1'b0;
        byte_count_next       = '0;
        announced_length_next = '0;
        running_sum_next      = '0;
      end
    end
  end

  // Bank ownership: set when a frame is queued, cleared when it has been drained.
  always_comb begin
    bank_busy_next = bank_busy;
    if (rel.valid) begin
      bank_busy_next[rel.bank] = 1'b0;
    end
    if (push_valid) begin
      bank_busy_next[wr_bank] = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value       <= SYNC_RESET;
      receiving        <= 1'b0;
      byte_count       <= '0;
      announced_length <= '0;
      running_sum      <= '0;
      wr_bank          <= 1'b0;
      bank_busy        <= '0;
    end else begin
      if (cfg_we) begin
        sync_value <= cfg_wdata;
      end
      receiving        <= receiving_next;
      byte_count       <= byte_count_next;
      announced_length <= announced_length_next;
      running_sum      <= running_sum_next;
      bank_busy        <= bank_busy_next;
      if (push_valid) begin
        wr_bank <= !wr_bank;
      end
    end
  end

endmodule

// ===== design/slcf_back.sv =====
// Back end: drains a verified frame from its RAM bank as a run of result items.
module slcf_back import slcf_pkg::*; #(
  parameter int MAX_PAYLOAD = 16,
  localparam int LW = $clog2(MAX_PAYLOAD + 1),
  localparam int PW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
  localparam int AW = $clog2(BANKS * MAX_PAYLOAD),
  localparam int DW = 1 + LW
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  input  logic [DW-1:0]     pop_desc,
  output logic              pop_ready,
  output logic              ram_re,
  output logic [AW-1:0]     ram_raddr,
  input  logic [BYTE_W-1:0] ram_rdata,
  slcf_res_if.source        res,
  output slcf_release_t     rel
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_READ = 3'b010,
    B_SEND = 3'b100
  } back_state_t;

  back_state_t   state;
  back_state_t   state_next;
  logic          bank;
  logic [LW-1:0] len;
  logic [PW-1:0] idx;
  logic [PW-1:0] idx_next;
  logic          last;

  assign pop_ready            = (state == B_IDLE);
  assign last                 = (LW'(idx) + LW'(1)) == len;
  assign ram_raddr            = AW'(idx) + (bank ? AW'(MAX_PAYLOAD) : {AW{1'b0}});
  assign res.valid            = (state == B_SEND);
  assign res.payload_byte     = ram_rdata;
  assign res.payload_position = POSITION_W'(idx);
  assign res.frame_length     = LENGTH_W'(len);
  assign res.last_of_frame    = last;

  // Sequencer: read one byte, then hold it on the result channel until taken.
  always_comb begin
    state_next = state;
    idx_next   = idx;
    ram_re     = 1'b0;
    rel.valid  = 1'b0;
    rel.bank   = bank;
    unique case (state)
      B_IDLE: begin
        if (pop_valid) begin
          idx_next   = '0;
          state_next = B_READ;
        end
      end
      B_READ: begin
        ram_re     = 1'b1;
        state_next = B_SEND;
      end
      B_SEND: begin
        if (res.ready) begin
          if (last) begin
            rel.valid  = 1'b1;
            state_next = B_IDLE;
          end else begin
            idx_next   = idx + PW'(1);
            state_next = B_READ;
          end
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // Frame descriptor registers, loaded when a frame is popped.
  always_ff @(posedge clk) begin
    if (state == B_IDLE && pop_valid) begin
      bank <= pop_desc[DW-1];
      len  <= pop_desc[LW-1:0];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule

// ===== design/sync_length_checksum_frame_receiver_top.sv =====
// A checksum match queues the frame descriptor; the back end pops it, reads the first
// payload byte, then offers it. Input takes one received byte per cycle unless stalled;
// results drain read-then-send on the RAM read port, each item taken before the next read.
// Two payload banks let a new frame arrive while the previous one drains; input
// stalls only while both banks hold frames not yet delivered.
// Reset (synchronous, active high) returns to sync hunting, sync value 0xAA, queue empty.
module sync_length_checksum_frame_receiver_top import slcf_pkg::*; #(
  parameter int MAX_PAYLOAD = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [BYTE_W-1:0] cfg_wdata,
  slcf_rx_if.sink           rx,
  slcf_res_if.source        res
);

  localparam int LW    = $clog2(MAX_PAYLOAD + 1);
  localparam int AW    = $clog2(BANKS * MAX_PAYLOAD);
  localparam int DW    = 1 + LW;
  localparam int DEPTH = BANKS * MAX_PAYLOAD;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic              push_valid;
  logic [DW-1:0]     push_desc;
  logic              push_ready;
  logic              pop_valid;
  logic [DW-1:0]     pop_desc;
  logic              pop_ready;
  slcf_release_t     rel;

  // Byte parser and checksum check.
  slcf_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .rx         (rx),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .push_valid (push_valid),
    .push_desc  (push_desc),
    .push_ready (push_ready),
    .rel        (rel)
  );

  // Verified frame descriptors.
  slcf_queue #(.WIDTH(DW)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_desc),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_desc),
    .pop_ready  (pop_ready)
  );

  // Payload store, two banks.
  slcf_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result run generator.
  slcf_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_desc  (pop_desc),
    .pop_ready (pop_ready),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res       (res),
    .rel       (rel)
  );

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the sync/length/checksum frame receiver.
module testbench;
  import slcf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PAYLOAD   = 16;
  localparam int SETTLE_CYCLES = 12;
  localparam int STALL_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 150;
  localparam int IDLE_PERCENT  = 23;

  typedef logic [BYTE_W-1:0] byte_t;

  // One payload byte of a verified frame, as seen on the result channel.
  typedef struct {
    byte_t                 data;
    logic [POSITION_W-1:0] position;
    logic [LENGTH_W-1:0]   frame_length;
    logic                  last_mark;
  } payload_item_t;

  // Tracks the frame parser state and holds the payload items still owed.
  class frame_predictor;
    byte_t         sync_value;
    bit            in_frame;
    logic [4:0]    byte_count;
    byte_t         announced_length;
    byte_t         running_sum;
    byte_t         payload_store[MAX_PAYLOAD];
    payload_item_t pending_payload[$];
    int unsigned   error_count;

    function new();
      sync_value  = SYNC_RESET;
      error_count = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      in_frame         = 1'b0;
      byte_count       = '0;
      announced_length = '0;
      running_sum      = '0;
    endfunction

    // Advances the parser by one accepted byte and queues any payload it releases.
    function void take_byte(byte_t b);
      payload_item_t item;
      if (!in_frame) begin
        if (b == sync_value) begin
          in_frame         = 1'b1;
          byte_count       = 5'd1;
          announced_length = '0;
          running_sum      = b;
        end
        return;
      end
      if (byte_count == 5'd1) begin
        if (b == 0 || b > MAX_PAYLOAD) begin
          clear_frame();
        end else begin
          announced_length = b;
          running_sum      = running_sum + b;
          byte_count       = 5'd2;
        end
        return;
      end
      if (byte_count < announced_length + 2) begin
        payload_store[byte_count - 2] = b;
        running_sum                   = running_sum + b;
        byte_count                    = byte_count + 5'd1;
        return;
      end
      // This is the checksum byte: a match releases the whole stored payload.
      if (b == running_sum) begin
        for (int i = 0; i < announced_length; i++) begin
          item.data         = payload_store[i];
          item.position     = POSITION_W'(i);
          item.frame_length = LENGTH_W'(announced_length);
          item.last_mark    = (i + 1 == announced_length);
          pending_payload.push_back(item);
        end
      end
      clear_frame();
    endfunction

    // Compares one delivered payload item with the oldest one owed.
    function void check_payload(payload_item_t got);
      payload_item_t want;
      if (pending_payload.size() == 0) begin
        $display("%0t: unexpected payload item, data %0h position %0d", $time,
                 got.data, got.position);
        error_count++;
        return;
      end
      want = pending_payload.pop_front();
      if (got.data !== want.data) begin
        $display("%0t: payload_byte expected %0h actual %0h", $time, want.data, got.data);
        error_count++;
      end
      if (got.position !== want.position) begin
        $display("%0t: payload_position expected %0d actual %0d", $time,
                 want.position, got.position);
        error_count++;
      end
      if (got.frame_length !== want.frame_length) begin
        $display("%0t: frame_length expected %0d actual %0d", $time,
                 want.frame_length, got.frame_length);
        error_count++;
      end
      if (got.last_mark !== want.last_mark) begin
        $display("%0t: last_of_frame expected %0b actual %0b", $time,
                 want.last_mark, got.last_mark);
        error_count++;
      end
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst;
  logic  cfg_we;
  byte_t cfg_wdata;

  slcf_rx_if  rx ();
  slcf_res_if res ();

  frame_predictor sb;
  bit             no_gaps      = 1'b0;
  bit             hold_request = 1'b0;

  sync_length_checksum_frame_receiver_top #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rx        (rx),
    .res       (res)
  );

  // Free-running clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Offers one byte, with random idle cycles ahead of it, and waits until it is taken.
  task automatic send_byte(input byte_t value);
    while (!no_gaps && $urandom_range(99) < IDLE_PERCENT) begin
      rx.valid <= 1'b0;
      @(posedge clk);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= value;
    do @(posedge clk); while (!rx.ready);
    sb.take_byte(value);
  endtask

  // Sends a whole frame with the current sync byte; a nonzero offset spoils the checksum.
  task automatic send_frame(input byte_t body[$], input byte_t check_offset);
    byte_t frame_sum;
    frame_sum = sb.sync_value + byte_t'(body.size());
    foreach (body[i]) frame_sum += body[i];
    send_byte(sb.sync_value);
    send_byte(byte_t'(body.size()));
    foreach (body[i]) send_byte(body[i]);
    send_byte(frame_sum + check_offset);
  endtask

  // Writes the sync register once all owed payload has been delivered.
  task automatic write_sync(input byte_t value);
    rx.valid <= 1'b0;
    while (sb.pending_payload.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we        <= 1'b0;
    sb.sync_value  = value;
  endtask

  // Mostly good frames of random content, plus bad checksums, bad lengths and noise.
  task automatic random_traffic(input int unsigned n_bytes);
    int unsigned sent;
    int unsigned pick;
    int unsigned len;
    int unsigned n_noise;
    byte_t       body[$];
    sent = 0;
    while (sent < n_bytes) begin
      pick = $urandom_range(99);
      len  = ($urandom_range(7) == 0) ? MAX_PAYLOAD : $urandom_range(1, 8);
      body.delete();
      repeat (len) body.push_back(byte_t'($urandom));
      if (pick < 68) begin
        send_frame(body, 8'h00);
        sent += len + 3;
      end else if (pick < 80) begin
        send_frame(body, byte_t'($urandom_range(1, 255)));
        sent += len + 3;
      end else if (pick < 90) begin
        send_byte(sb.sync_value);
        send_byte($urandom_range(1) ? 8'h00 : byte_t'($urandom_range(MAX_PAYLOAD + 1, 255)));
        sent += 2;
      end else begin
        n_noise = $urandom_range(1, 3);
        repeat (n_noise) send_byte(byte_t'($urandom));
        sent += n_noise;
      end
    end
  endtask

  // Result side: random back-pressure, one long hold on request, and checking.
  initial begin
    int unsigned   hold_left;
    payload_item_t got;
    hold_left = 0;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= no_gaps || ($urandom_range(99) >= IDLE_PERCENT);
      end
      @(posedge clk);
      if (res.valid && res.ready) begin
        got.data         = res.payload_byte;
        got.position     = res.payload_position;
        got.frame_length = res.frame_length;
        got.last_mark    = res.last_of_frame;
        sb.check_payload(got);
      end
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst || (rx.valid && rx.ready) || (res.valid && res.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed frames, then random phases over several sync values.
  initial begin
    byte_t body[$];
    byte_t old_sync;
    byte_t frame_sum;
    sb          = new();
    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    rx.valid   <= 1'b0;
    rx.rx_byte <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Shortest good frame with an all-ones payload byte.
    body.delete();
    body.push_back(8'hFF);
    send_frame(body, 8'h00);
    // Length of zero and length just above the maximum both drop the frame.
    send_byte(sb.sync_value);
    send_byte(8'h00);
    send_byte(sb.sync_value);
    send_byte(byte_t'(MAX_PAYLOAD + 1));
    // Wrong checksum is dropped silently.
    body.delete();
    body.push_back(8'h00);
    send_frame(body, 8'h01);
    // Sync byte inside the payload is plain data and does not restart the frame.
    body.delete();
    body.push_back(sb.sync_value);
    body.push_back(8'h00);
    body.push_back(8'hFF);
    send_frame(body, 8'h00);
    // Non-sync bytes while hunting are ignored.
    send_byte(8'h00);
    send_byte(8'h55);

    // Long hold on the result side: three short good frames fill both banks and
    // the third one stalls the input until the hold ends.
    hold_request = 1'b1;
    repeat (3) begin
      body.delete();
      body.push_back(byte_t'($urandom));
      send_frame(body, 8'h00);
    end
    random_traffic(44);

    write_sync(8'h00);
    random_traffic(44);

    // Sync register changes mid-frame: the frame keeps its own sync byte in the sum.
    write_sync(8'h00);
    old_sync = sb.sync_value;
    body.delete();
    repeat (4) body.push_back(byte_t'($urandom));
    frame_sum = old_sync + 8'd4;
    foreach (body[i]) frame_sum += body[i];
    send_byte(old_sync);
    send_byte(8'd4);
    send_byte(body[0]);
    send_byte(body[1]);
    write_sync(8'hFF);
    send_byte(body[2]);
    send_byte(body[3]);
    send_byte(frame_sum);

    // Back-to-back stretch with no idling on either side.
    no_gaps = 1'b1;
    random_traffic(44);
    no_gaps = 1'b0;

    write_sync(byte_t'($urandom_range(255)));
    random_traffic(44);

    write_sync(SYNC_RESET);
    random_traffic(44);

    // Drain everything still owed, then let the pipeline settle.
    rx.valid <= 1'b0;
    while (sb.pending_payload.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/slcf_pkg.sv
design/slcf_rx_if.sv
design/slcf_res_if.sv
design/slcf_ram.sv
design/slcf_queue.sv
design/slcf_front.sv
design/slcf_back.sv
design/sync_length_checksum_frame_receiver_top.sv
verif/testbench.sv
